/* rtl/fmrws_pkg.sv */
package fmrws_pkg;

    localparam int EVENT_DEPTH_DEF         = 4096;
    localparam int KEY_TRACKS_DEF          = 10;
    localparam int MAX_WRITES_PER_TICK_DEF = 64;

    localparam int ADDR_W  = 12;
    localparam int REG_W   = 8;
    localparam int VAL_W   = 8;
    localparam int DELAY_W = 16;
    localparam int SONG_W  = 13;
    localparam int LEN_W   = 17;
    localparam int TIME_W  = 32;
    localparam int EVENT_W = REG_W + VAL_W + DELAY_W;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = REG_W + VAL_W;
    localparam int CFG_DATA_W = SONG_W;
    localparam int CFG_IDX_W  = 1;

    localparam logic [REG_W-1:0] REG_EFFECTS  = 8'hbd;
    localparam logic [REG_W-1:0] REG_KEY_BASE = 8'hb0;

    localparam logic [CFG_IDX_W-1:0] CFG_MUSIC_ENABLED = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SONG_EVENTS   = 1'b1;

    typedef enum logic [1:0] {
        K_LOAD  = 2'd0,
        K_TICK  = 2'd1,
        K_START = 2'd2,
        K_STOP  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SIL,
        S_TCHK,
        S_TEMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic disarm;
        logic sil_init;
        logic sil_emit;
        logic arm;
        logic tick_init;
        logic tick_rd;
        logic ev_emit;
        logic tick_end;
    } t_cmd;

    typedef struct packed {
        logic playing;
        logic enabled;
        logic out_free;
        logic sil_done;
        logic tick_go;
    } t_sts;

endpackage

/* rtl/fm_register_write_sequencer_unit.sv */
// Sequencer that plays a song of timed FM synthesizer register writes. A load item
// writes one entry of the event store; the store is not cleared at reset, so every
// entry a song reaches must be loaded first. A start or stop item, when music is
// enabled, sends 11 silencing writes, one per cycle while the output is free. A tick
// emits up to 64 writes through the single event-store read port: each due event is
// one registered read, then one load of the output register. A held output stalls
// the sequencer until it is taken. Only one item is worked on at a time; s_axis_tready
// is high while the sequencer is idle.
module fm_register_write_sequencer_unit #(
    parameter int EVENT_DEPTH         = fmrws_pkg::EVENT_DEPTH_DEF,
    parameter int KEY_TRACKS          = fmrws_pkg::KEY_TRACKS_DEF,
    parameter int MAX_WRITES_PER_TICK = fmrws_pkg::MAX_WRITES_PER_TICK_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // event_address, event_register, event_value, event_delay, zero pad
    input  logic [fmrws_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // kind
    input  logic [1:0]                            s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // write_register, write_value
    output logic [fmrws_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                                  m_axis_tlast,
    input  logic                                  i_cfg_we,
    input  logic [fmrws_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [fmrws_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    fmrws_pkg::t_cmd cmd;
    fmrws_pkg::t_sts sts;
    logic [fmrws_pkg::REG_W-1:0] write_register;
    logic [fmrws_pkg::VAL_W-1:0] write_value;

    fmrws_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_kind  (s_axis_tuser),
        .o_ready (s_axis_tready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    fmrws_dp #(
        .EVENT_DEPTH         (EVENT_DEPTH),
        .KEY_TRACKS          (KEY_TRACKS),
        .MAX_WRITES_PER_TICK (MAX_WRITES_PER_TICK)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_event_address  (s_axis_tdata[11:0]),
        .i_event_register (s_axis_tdata[19:12]),
        .i_event_value    (s_axis_tdata[27:20]),
        .i_event_delay    (s_axis_tdata[43:28]),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_out_valid      (m_axis_tvalid),
        .i_out_ready      (m_axis_tready),
        .o_write_register (write_register),
        .o_write_value    (write_value),
        .o_last           (m_axis_tlast)
    );

    assign m_axis_tdata = {write_value, write_register};

endmodule

/* rtl/fmrws_ctrl.sv */
module fmrws_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [1:0]       i_kind,
    output logic             o_ready,
    input  fmrws_pkg::t_sts  i_sts,
    output fmrws_pkg::t_cmd  o_cmd
);

    fmrws_pkg::t_state r_state, n_state;
    logic              r_start, n_start;
    fmrws_pkg::t_kind  kind;

    assign kind = fmrws_pkg::t_kind'(i_kind);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fmrws_pkg::S_IDLE;
            r_start <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= n_start;
        end
    end

    always_comb begin
        n_state = r_state;
        n_start = r_start;
        o_ready = 1'b0;
        o_cmd   = '0;
        case (r_state)
            fmrws_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    case (kind)
                        fmrws_pkg::K_LOAD: begin
                            o_cmd.load = 1'b1;
                        end
                        fmrws_pkg::K_TICK: begin
                            if (i_sts.playing) begin
                                o_cmd.tick_init = 1'b1;
                                n_state         = fmrws_pkg::S_TCHK;
                            end
                        end
                        default: begin
                            o_cmd.disarm = 1'b1;
                            if (i_sts.enabled) begin
                                o_cmd.sil_init = 1'b1;
                                n_start        = (kind == fmrws_pkg::K_START);
                                n_state        = fmrws_pkg::S_SIL;
                            end
                        end
                    endcase
                end
            end
            fmrws_pkg::S_SIL: begin
                if (i_sts.out_free) begin
                    o_cmd.sil_emit = 1'b1;
                    if (i_sts.sil_done) begin
                        o_cmd.arm = r_start;
                        n_state   = fmrws_pkg::S_IDLE;
                    end
                end
            end
            fmrws_pkg::S_TCHK: begin
                if (i_sts.tick_go) begin
                    o_cmd.tick_rd = 1'b1;
                    n_state       = fmrws_pkg::S_TEMIT;
                end else begin
                    o_cmd.tick_end = 1'b1;
                    n_state        = fmrws_pkg::S_IDLE;
                end
            end
            fmrws_pkg::S_TEMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.ev_emit = 1'b1;
                    n_state       = fmrws_pkg::S_TCHK;
                end
            end
            default: begin
                n_state = fmrws_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/fmrws_dp.sv */
module fmrws_dp #(
    parameter int EVENT_DEPTH         = fmrws_pkg::EVENT_DEPTH_DEF,
    parameter int KEY_TRACKS          = fmrws_pkg::KEY_TRACKS_DEF,
    parameter int MAX_WRITES_PER_TICK = fmrws_pkg::MAX_WRITES_PER_TICK_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  fmrws_pkg::t_cmd                     i_cmd,
    output fmrws_pkg::t_sts                     o_sts,
    input  logic [fmrws_pkg::ADDR_W-1:0]        i_event_address,
    input  logic [fmrws_pkg::REG_W-1:0]         i_event_register,
    input  logic [fmrws_pkg::VAL_W-1:0]         i_event_value,
    input  logic [fmrws_pkg::DELAY_W-1:0]       i_event_delay,
    input  logic                                i_cfg_we,
    input  logic [fmrws_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fmrws_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [fmrws_pkg::REG_W-1:0]         o_write_register,
    output logic [fmrws_pkg::VAL_W-1:0]         o_write_value,
    output logic                                o_last
);

    localparam int AW = $clog2(EVENT_DEPTH);
    localparam int SW = $clog2(KEY_TRACKS + 1);
    localparam int CW = $clog2(MAX_WRITES_PER_TICK + 1);
    localparam logic [fmrws_pkg::LEN_W-1:0] DEPTH_L = fmrws_pkg::LEN_W'(EVENT_DEPTH);

    logic [fmrws_pkg::EVENT_W-1:0] mem [EVENT_DEPTH];

    logic [fmrws_pkg::EVENT_W-1:0] r_rd_data;
    logic [fmrws_pkg::SONG_W-1:0]  r_play_index;
    logic [fmrws_pkg::TIME_W-1:0]  r_next_due;
    logic [fmrws_pkg::TIME_W-1:0]  r_tick_count;
    logic                          r_playing;
    logic                          r_enabled;
    logic [fmrws_pkg::SONG_W-1:0]  r_song_events;
    logic [SW-1:0]                 r_sil_cnt;
    logic [CW-1:0]                 r_wr_cnt;
    logic                          r_out_valid;
    logic [fmrws_pkg::REG_W-1:0]   r_out_reg;
    logic [fmrws_pkg::VAL_W-1:0]   r_out_val;
    logic                          r_out_last;

    logic [fmrws_pkg::LEN_W-1:0]   song_len;
    logic [fmrws_pkg::LEN_W-1:0]   idx_l;
    logic [fmrws_pkg::LEN_W-1:0]   idx_next_l;
    logic [fmrws_pkg::TIME_W-1:0]  n_next_due;
    logic                          ev_last;
    logic                          sil_done;
    logic [fmrws_pkg::REG_W-1:0]   sil_reg;
    logic                          load_ok;

    assign song_len = (fmrws_pkg::LEN_W'(r_song_events) < DEPTH_L)
                      ? fmrws_pkg::LEN_W'(r_song_events) : DEPTH_L;
    assign idx_l      = fmrws_pkg::LEN_W'(r_play_index);
    assign idx_next_l = idx_l + fmrws_pkg::LEN_W'(1);
    assign n_next_due = r_tick_count
                        + fmrws_pkg::TIME_W'(r_rd_data[fmrws_pkg::EVENT_W-1 -: fmrws_pkg::DELAY_W]);
    assign ev_last    = (n_next_due > r_tick_count) || (idx_next_l >= song_len)
                        || (r_wr_cnt == CW'(MAX_WRITES_PER_TICK - 1));
    assign sil_done   = (r_sil_cnt == SW'(KEY_TRACKS));
    assign sil_reg    = (r_sil_cnt == '0) ? fmrws_pkg::REG_EFFECTS
                        : fmrws_pkg::REG_KEY_BASE + fmrws_pkg::REG_W'(r_sil_cnt);
    assign load_ok    = (fmrws_pkg::LEN_W'(i_event_address) < DEPTH_L);

    assign o_sts.playing  = r_playing;
    assign o_sts.enabled  = r_enabled;
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_sts.sil_done = sil_done;
    assign o_sts.tick_go  = (idx_l < song_len) && (r_wr_cnt < CW'(MAX_WRITES_PER_TICK))
                            && (r_next_due <= r_tick_count);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && load_ok) begin
            mem[AW'(i_event_address)] <= {i_event_delay, i_event_value, i_event_register};
        end
        if (i_cmd.tick_rd) begin
            r_rd_data <= mem[AW'(r_play_index)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_play_index  <= '0;
            r_next_due    <= '0;
            r_tick_count  <= '0;
            r_playing     <= 1'b0;
            r_enabled     <= 1'b0;
            r_song_events <= '0;
            r_sil_cnt     <= '0;
            r_wr_cnt      <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    fmrws_pkg::CFG_MUSIC_ENABLED: r_enabled <= i_cfg_data[0];
                    fmrws_pkg::CFG_SONG_EVENTS:   r_song_events <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_ready && !i_cmd.sil_emit && !i_cmd.ev_emit) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.disarm) begin
                r_playing <= 1'b0;
            end
            if (i_cmd.sil_init) begin
                r_sil_cnt <= '0;
            end
            if (i_cmd.sil_emit) begin
                r_sil_cnt   <= r_sil_cnt + SW'(1);
                r_out_valid <= 1'b1;
            end
            if (i_cmd.arm) begin
                r_play_index <= '0;
                r_next_due   <= '0;
                r_tick_count <= '0;
                r_playing    <= 1'b1;
            end
            if (i_cmd.tick_init) begin
                r_wr_cnt <= '0;
            end
            if (i_cmd.ev_emit) begin
                r_next_due   <= n_next_due;
                r_play_index <= r_play_index + fmrws_pkg::SONG_W'(1);
                r_wr_cnt     <= r_wr_cnt + CW'(1);
                r_out_valid  <= 1'b1;
            end
            if (i_cmd.tick_end) begin
                if (idx_l >= song_len) begin
                    r_play_index <= '0;
                    r_next_due   <= '0;
                    r_tick_count <= '0;
                end else begin
                    r_tick_count <= r_tick_count + fmrws_pkg::TIME_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sil_emit) begin
            r_out_reg  <= sil_reg;
            r_out_val  <= '0;
            r_out_last <= sil_done;
        end else if (i_cmd.ev_emit) begin
            r_out_reg  <= r_rd_data[fmrws_pkg::REG_W-1:0];
            r_out_val  <= r_rd_data[fmrws_pkg::REG_W +: fmrws_pkg::VAL_W];
            r_out_last <= ev_last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_write_register = r_out_reg;
    assign o_write_value    = r_out_val;
    assign o_last           = r_out_last;

endmodule

/* rtl/fmrws_checker.sv */
module fmrws_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [1:0]                       s_axis_tuser,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [fmrws_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                             m_axis_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled result changed");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_load_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == fmrws_pkg::K_LOAD)
            |=> s_axis_tready)
        else $error("load item did not finish in one cycle");

    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready)
        else $error("item accepted before the current one finished");

endmodule

bind fm_register_write_sequencer_unit fmrws_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
